FILE: rtl/tprc_pkg.sv
// Package for the two-pole resonator: widths, register indexes, coefficient
// magnitude table and the code-to-coefficient decode.
// No dependencies.
package tprc_pkg;

   // sample format and recursion state
   localparam int SAMPLE_FRAC_BITS = 12;
   localparam int STATE_WIDTH      = 20;

   // fixed field widths
   localparam int IN_W   = 14;
   localparam int OUT_W  = 14;
   localparam int CODE_W = 8;
   localparam int DATA_W = 16;   // tdata width, whole bytes
   localparam int USER_W = 1;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_BANDWIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FREQUENCY = CSR_IDX_W'(1);

   // coefficient arithmetic
   localparam int COEF_SHIFT = 9;
   localparam int COEF_W     = 10;                          // -511..+511
   localparam int PROD_W     = STATE_WIDTH + COEF_W;
   localparam int TERM_F_W   = PROD_W - (COEF_SHIFT - 1);   // 2*F*z1 >> 9
   localparam int TERM_B_W   = PROD_W - COEF_SHIFT;         // B*z2 >> 9
   localparam int SUM_W      = TERM_F_W + 2;

   // saturation and clamp limits in the sum domain
   localparam logic signed [SUM_W-1:0] STATE_HI =
      SUM_W'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] STATE_LO = -STATE_HI - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] ONE_POS  = SUM_W'(64'sd1 <<< SAMPLE_FRAC_BITS);
   localparam logic signed [SUM_W-1:0] ONE_NEG  = -ONE_POS;

   typedef logic signed [COEF_W-1:0] coef_type;

   // coefficient magnitudes, 9 fractional bits
   localparam logic [8:0] MAG_TABLE [128] = '{
      9'd0,   9'd9,   9'd12,  9'd25,  9'd33,  9'd41,  9'd49,  9'd57,
      9'd65,  9'd73,  9'd81,  9'd89,  9'd97,  9'd105, 9'd113, 9'd121,
      9'd129, 9'd137, 9'd145, 9'd153, 9'd161, 9'd169, 9'd177, 9'd185,
      9'd193, 9'd201, 9'd209, 9'd217, 9'd225, 9'd233, 9'd241, 9'd249,
      9'd257, 9'd265, 9'd273, 9'd281, 9'd289, 9'd297, 9'd301, 9'd305,
      9'd309, 9'd313, 9'd317, 9'd321, 9'd325, 9'd329, 9'd333, 9'd337,
      9'd341, 9'd345, 9'd349, 9'd353, 9'd357, 9'd361, 9'd365, 9'd369,
      9'd373, 9'd377, 9'd381, 9'd385, 9'd389, 9'd393, 9'd397, 9'd401,
      9'd405, 9'd409, 9'd413, 9'd417, 9'd421, 9'd425, 9'd427, 9'd429,
      9'd431, 9'd433, 9'd435, 9'd437, 9'd439, 9'd441, 9'd443, 9'd445,
      9'd447, 9'd449, 9'd451, 9'd453, 9'd455, 9'd457, 9'd459, 9'd461,
      9'd463, 9'd465, 9'd467, 9'd469, 9'd471, 9'd473, 9'd475, 9'd477,
      9'd479, 9'd481, 9'd482, 9'd483, 9'd484, 9'd485, 9'd486, 9'd487,
      9'd488, 9'd489, 9'd490, 9'd491, 9'd492, 9'd493, 9'd494, 9'd495,
      9'd496, 9'd497, 9'd498, 9'd499, 9'd500, 9'd501, 9'd502, 9'd503,
      9'd504, 9'd505, 9'd506, 9'd507, 9'd508, 9'd509, 9'd510, 9'd511
   };

   // top bit set: +table[(-code) & 0x7F], else -table[code & 0x7F]
   function automatic coef_type decode_coef(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] neg_code;
      logic [COEF_W-1:0] mag;
      begin
         neg_code = ~code + CODE_W'(1);
         if (code[CODE_W-1]) begin
            mag = COEF_W'(MAG_TABLE[neg_code[CODE_W-2:0]]);
            decode_coef = coef_type'(mag);
         end else begin
            mag = COEF_W'(MAG_TABLE[code[CODE_W-2:0]]);
            decode_coef = coef_type'(-mag);
         end
      end
   endfunction

endpackage

FILE: rtl/two_pole_resonator_coded_coef.sv
// Two-pole resonator with coefficients decoded from 8-bit codes.
// Depends on tprc_pkg (widths, limits, coefficient table and decode).
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  req_     | in        | tdata[13:0] excitation (signed)
//  rsp_     | out       | tdata[13:0] filtered_sample (signed), tuser clipped
//  csr_     | in        | index 0 bandwidth_code, index 1 frequency_code
//
// One beat per cycle while the response is not stalled; a request beat passes
// through the input register, then the feedback multiply-add into the result
// register. The recursion closes through the delay registers alone: two 20x10
// multipliers in parallel, one three-input add and a saturate.
// Synchronous reset clears codes, delay state and both valid flags.
// A stalled response holds the input register; a new request beat is taken
// whenever the input register is empty or moves on in the same cycle.
module two_pole_resonator_coded_coef (
   input  logic                         clock,
   input  logic                         reset,
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tprc_pkg::DATA_W-1:0]  req_tdata,   // [13:0] excitation
   // response stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tprc_pkg::DATA_W-1:0]  rsp_tdata,   // [13:0] filtered_sample
   output logic [tprc_pkg::USER_W-1:0]  rsp_tuser,   // [0] clipped
   // register writes
   input  logic                         csr_we,
   input  logic [tprc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tprc_pkg::CODE_W-1:0]  csr_wdata
);
   import tprc_pkg::*;

   logic                          in_valid_ff, in_valid_in;
   logic signed [IN_W-1:0]        in_sample_ff, in_sample_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0]       out_sample_ff, out_sample_in;
   logic                          out_clip_ff, out_clip_in;
   logic [CODE_W-1:0]             bw_code_ff, bw_code_in;
   logic [CODE_W-1:0]             fq_code_ff, fq_code_in;
   logic signed [STATE_WIDTH-1:0] delay_one_ff, delay_one_in;
   logic signed [STATE_WIDTH-1:0] delay_two_ff, delay_two_in;

   logic                          advance;
   coef_type                      coef_f, coef_b;
   logic signed [PROD_W-1:0]      prod_f, prod_b;
   logic signed [TERM_F_W-1:0]    term_f;
   logic signed [TERM_B_W-1:0]    term_b;
   logic signed [SUM_W-1:0]       sum;
   logic signed [SUM_W-1:0]       y_sat;
   logic signed [SUM_W-1:0]       y_clamp;
   logic                          clip;

   // beat moves from input register to result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // feedback multiply-add; floor shifts are plain part-selects
   always_comb begin
      coef_f = decode_coef(fq_code_ff);
      coef_b = decode_coef(bw_code_ff);
      prod_f = PROD_W'(coef_f) * PROD_W'(delay_one_ff);
      prod_b = PROD_W'(coef_b) * PROD_W'(delay_two_ff);
      term_f = prod_f[PROD_W-1:COEF_SHIFT-1];   // (2*F*z1) >>> 9
      term_b = prod_b[PROD_W-1:COEF_SHIFT];     // (B*z2) >>> 9
      sum    = SUM_W'(in_sample_ff) + SUM_W'(term_f) + SUM_W'(term_b);

      // saturate to the state width
      if (sum > STATE_HI) begin
         y_sat = STATE_HI;
      end else if (sum < STATE_LO) begin
         y_sat = STATE_LO;
      end else begin
         y_sat = sum;
      end

      // clamp the output to +/-1.0
      clip = 1'b0;
      if (y_sat > ONE_POS) begin
         y_clamp = ONE_POS;
         clip    = 1'b1;
      end else if (y_sat < ONE_NEG) begin
         y_clamp = ONE_NEG;
         clip    = 1'b1;
      end else begin
         y_clamp = y_sat;
      end
   end

   // next values
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_sample_in  = in_sample_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_clip_in   = out_clip_ff;
      bw_code_in    = bw_code_ff;
      fq_code_in    = fq_code_ff;
      delay_one_in  = delay_one_ff;
      delay_two_in  = delay_two_ff;

      // input register
      if (req_tvalid && req_tready) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_tdata[IN_W-1:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // result register and state update
      if (advance) begin
         out_valid_in  = 1'b1;
         out_sample_in = y_clamp[OUT_W-1:0];
         out_clip_in   = clip;
         delay_two_in  = delay_one_ff;
         delay_one_in  = y_sat[STATE_WIDTH-1:0];
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // register writes; unknown indexes ignored
      if (csr_we) begin
         case (csr_index)
            REG_BANDWIDTH: bw_code_in = csr_wdata;
            REG_FREQUENCY: fq_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bw_code_ff   <= '0;
         fq_code_ff   <= '0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         bw_code_ff   <= bw_code_in;
         fq_code_ff   <= fq_code_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      out_sample_ff <= out_sample_in;
      out_clip_ff   <= out_clip_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(DATA_W-OUT_W){1'b0}}, out_sample_ff};
   assign rsp_tuser  = out_clip_ff;

endmodule

FILE: rtl/tprc_checker.sv
// Port-level checks for the two-pole resonator, bound to the top level.
// Depends on tprc_pkg and two_pole_resonator_coded_coef.
module tprc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tprc_pkg::DATA_W-1:0]    rsp_tdata,
   input logic [tprc_pkg::USER_W-1:0]    rsp_tuser
);
   import tprc_pkg::*;

   logic signed [OUT_W-1:0] rsp_sample;
   logic signed [OUT_W-1:0] lim_pos, lim_neg;

   assign rsp_sample = rsp_tdata[OUT_W-1:0];
   assign lim_pos    = ONE_POS[OUT_W-1:0];
   assign lim_neg    = ONE_NEG[OUT_W-1:0];

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed under stall");

   // clip flag only with the sample at a limit
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_sample == lim_pos || rsp_sample == lim_neg)
      else $error("clip flag without a limit value");

   // unclipped samples stay within +/-1.0
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_sample <= lim_pos && rsp_sample >= lim_neg)
      else $error("unclipped sample out of range");

   // no response straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind two_pole_resonator_coded_coef tprc_checker u_tprc_checker (.*);
